FILE: src/epoch_to_calendar_assert.svh
// Assertion macros shared by the epoch_to_calendar RTL.
// Each macro expects the clock aclk and the active-low reset aresetn in scope.
`ifndef EPOCH_TO_CALENDAR_ASSERT_SVH
`define EPOCH_TO_CALENDAR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define E2C_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define E2C_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/e2c_pkg.sv
// Constants and helper tables for the epoch_to_calendar block.
// No dependencies; used by epoch_to_calendar.
package e2c_pkg;

    // Calendar window reported by the block.
    localparam int BASE_YEAR = 2020;
    localparam int YEAR_SPAN = 64;

    // Field widths.
    localparam int TS_W   = 32;
    localparam int OFS_W  = 17;
    localparam int YEAR_W = 12;

    // Seconds from 1970-01-01 to 2000-03-01, both 00:00:00 UTC.
    localparam logic [TS_W-1:0] MAR2000_EPOCH = 32'(946684800 + 86400 * 60);

    // Cycle lengths in days of the March-first calendar.
    localparam int DAYS_100Y = 365 * 100 + 24;
    localparam int DAYS_4Y   = 365 * 4 + 1;
    localparam int DAYS_1Y   = 365;

    // Seconds per day split as 128 * 675, so the low 7 bits pass around the divider.
    localparam int DAY_LOW_BITS = 7;
    localparam int DAY_DIVISOR  = 86400 / 128;

    // Day within a March-first year at which each month starts (March first).
    localparam logic [8:0] MONTH_START [12] = '{
        9'd0, 9'd31, 9'd61, 9'd92, 9'd122, 9'd153,
        9'd184, 9'd214, 9'd245, 9'd275, 9'd306, 9'd337
    };

    // Month index 0..11 (0 = March) for a day of the March-first year.
    function automatic logic [3:0] month_index(input logic [8:0] day_of_year);
        logic [3:0] idx;
        idx = 4'd0;
        for (int i = 1; i < 12; i++) begin
            if (day_of_year >= MONTH_START[i]) begin
                idx = 4'(i);
            end
        end
        return idx;
    endfunction

endpackage

FILE: src/e2c_cdiv.sv
// Two-stage divider by a constant: reciprocal multiply, then one correction step.
// Uses no package items; instantiated by epoch_to_calendar.
module e2c_cdiv #(
    parameter int DW      = 25,
    parameter int QW      = 16,
    parameter int RW      = 10,
    parameter int DIVISOR = 675,
    parameter int SHIFT   = 35
) (
    input  logic          aclk,
    input  logic          en,
    input  logic [DW-1:0] dividend,
    output logic [QW-1:0] quotient,
    output logic [RW-1:0] remainder
);

    // The reciprocal is rounded down, so the estimate is the quotient or one less.
    localparam longint unsigned RECIP = (64'd1 << SHIFT) / DIVISOR;
    localparam int MW = $clog2(RECIP + 1);
    localparam logic [MW-1:0] RECIP_C = MW'(RECIP);
    localparam logic [DW-1:0] DIV_C   = DW'(DIVISOR);

    logic [DW+MW-1:0] prod;
    logic [QW-1:0]    est_next, est_reg;
    logic [DW-1:0]    dvd_reg;
    logic [DW-1:0]    back_prod;
    logic [DW-1:0]    diff;
    logic             fix;
    logic [QW-1:0]    quo_next, quo_reg;
    logic [RW-1:0]    rem_next, rem_reg;

    // First stage: quotient estimate from the reciprocal product.
    assign prod     = {{MW{1'b0}}, dividend} * {{DW{1'b0}}, RECIP_C};
    assign est_next = prod[SHIFT +: QW];

    always_ff @(posedge aclk) begin
        if (en) begin
            est_reg <= est_next;
            dvd_reg <= dividend;
        end
    end

    // Second stage: remainder of the estimate, bumped once if it reaches the divisor.
    assign back_prod = DW'(est_reg) * DIV_C;
    assign diff      = dvd_reg - back_prod;
    assign fix       = (diff >= DIV_C);
    assign quo_next  = est_reg + QW'(fix);
    assign rem_next  = fix ? RW'(diff - DIV_C) : RW'(diff);

    always_ff @(posedge aclk) begin
        if (en) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

FILE: src/epoch_to_calendar.sv
// Top level of the Unix timestamp to calendar converter (nine-stage pipeline).
// Depends on e2c_pkg, e2c_cdiv and epoch_to_calendar_assert.svh.
//
// Channel   Direction  Handshake          Payload
// s_        in         s_tvalid/s_tready  s_tdata: timestamp
// m_        out        m_tvalid/m_tready  m_tuser: in_range; m_tdata: date and time
// cfg_      in         cfg_wen            cfg_wdata: time zone offset in seconds
//
// A result is offered from the output stage; one item can enter every cycle while the
// output is not stalled. The nine register stages are the offset stage, the day divider,
// the century stage, the 4-year divider (each divider a multiply and a correction stage),
// the year, month and output stages; hours and minutes are divided alongside.
// Reset clears the valid bits and the offset register to zero.
// A stalled output freezes the whole pipeline and drops s_tready in the same cycle.
`include "epoch_to_calendar_assert.svh"

module epoch_to_calendar (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration register.
    input  logic        cfg_wen,
    input  logic [16:0] cfg_wdata,   // time zone offset in seconds, two's complement
    // Input items.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,     // [31:0] timestamp
    // Result items.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic        m_tuser,     // [0] in_range
    output logic [31:0] m_tdata      // [5:0] year_offset, [9:6] month, [14:10] day,
                                     // [19:15] hour, [25:20] minute, [31:26] second
);

    localparam int NSTAGE = 9;
    localparam logic [e2c_pkg::YEAR_W-1:0] YEAR_LO = 12'(e2c_pkg::BASE_YEAR);
    localparam logic [e2c_pkg::YEAR_W-1:0] YEAR_HI =
        12'(e2c_pkg::BASE_YEAR + e2c_pkg::YEAR_SPAN - 1);

    logic                     en;
    logic [NSTAGE-1:0]        valid_next, valid_reg;
    logic [e2c_pkg::OFS_W-1:0] offset_reg;

    // Stage 1 signals.
    logic [31:0] shifted_t;
    logic [31:0] secs_next, secs_s1_reg;
    logic        pre_next, pre_s1_reg;

    // Stages 2 and 3 signals.
    logic [6:0]  lo7_s2_reg, lo7_s3_reg;
    logic        pre_s2_reg, pre_s3_reg;
    logic [15:0] days_s3;
    logic [9:0]  rday_s3;

    // Stage 4 signals.
    logic        c100_next, c100_s4_reg;
    logic [15:0] rd1_next, rd1_s4_reg;
    logic [16:0] rems_next, rems_s4_reg;
    logic        pre_s4_reg;

    // Stages 5 and 6 signals.
    logic        c100_s5_reg, c100_s6_reg;
    logic        pre_s5_reg, pre_s6_reg;
    logic [4:0]  c4_s6;
    logic [10:0] rd2_s6;
    logic [4:0]  hour_s6;
    logic [11:0] rh_s6;

    // Stage 7 signals.
    logic [1:0]  c1_next, c1_s7_reg;
    logic [8:0]  rd3_next, rd3_s7_reg;
    logic [4:0]  c4_s7_reg;
    logic        c100_s7_reg;
    logic [4:0]  hour_s7_reg;
    logic        pre_s7_reg;

    // Stage 8 signals.
    logic [3:0]  mon_next, mon_s8_reg;
    logic [4:0]  day_next, day_s8_reg;
    logic [11:0] years_next, years_s8_reg;
    logic [4:0]  hour_s8_reg;
    logic        pre_s8_reg;
    logic [5:0]  minute_s8;
    logic [5:0]  second_s8;

    // Stage 9 (output) signals.
    logic [3:0]  mon_shift;
    logic        mon_wrap;
    logic [3:0]  month_calc;
    logic [11:0] years_calc;
    logic        in_range_calc;
    logic        tuser_next, tuser_reg;
    logic [31:0] tdata_next, tdata_reg;

    // The whole pipeline advances unless a result is waiting on the output.
    assign en       = !valid_reg[NSTAGE-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = valid_reg[NSTAGE-1];
    assign m_tuser  = tuser_reg;
    assign m_tdata  = tdata_reg;

    // Offset register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg <= '0;
        end else if (cfg_wen) begin
            offset_reg <= cfg_wdata;
        end
    end

    // Valid bits travel with the items.
    assign valid_next = {valid_reg[NSTAGE-2:0], s_tvalid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= valid_next;
        end
    end

    // Stage 1: apply the offset with 32-bit wrap and count seconds from March 2000.
    assign shifted_t = s_tdata + {{(32 - e2c_pkg::OFS_W){offset_reg[e2c_pkg::OFS_W-1]}},
                                  offset_reg};
    assign pre_next  = (shifted_t < e2c_pkg::MAR2000_EPOCH);
    assign secs_next = shifted_t - e2c_pkg::MAR2000_EPOCH;

    always_ff @(posedge aclk) begin
        if (en) begin
            secs_s1_reg <= secs_next;
            pre_s1_reg  <= pre_next;
        end
    end

    // Stages 2 and 3: days and seconds of day, dividing the upper bits by 675.
    e2c_cdiv #(
        .DW(25), .QW(16), .RW(10), .DIVISOR(e2c_pkg::DAY_DIVISOR), .SHIFT(35)
    ) u_day_div (
        .aclk      (aclk),
        .en        (en),
        .dividend  (secs_s1_reg[31:e2c_pkg::DAY_LOW_BITS]),
        .quotient  (days_s3),
        .remainder (rday_s3)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            lo7_s2_reg <= secs_s1_reg[e2c_pkg::DAY_LOW_BITS-1:0];
            lo7_s3_reg <= lo7_s2_reg;
            pre_s2_reg <= pre_s1_reg;
            pre_s3_reg <= pre_s2_reg;
        end
    end

    // Stage 4: century split (the day count never reaches a 400-year cycle).
    assign c100_next = (days_s3 >= 16'(e2c_pkg::DAYS_100Y));
    assign rd1_next  = c100_next ? days_s3 - 16'(e2c_pkg::DAYS_100Y) : days_s3;
    assign rems_next = {rday_s3, lo7_s3_reg};

    always_ff @(posedge aclk) begin
        if (en) begin
            c100_s4_reg <= c100_next;
            rd1_s4_reg  <= rd1_next;
            rems_s4_reg <= rems_next;
            pre_s4_reg  <= pre_s3_reg;
        end
    end

    // Stages 5 and 6: 4-year cycles of the day, and hours of the second count.
    e2c_cdiv #(
        .DW(16), .QW(5), .RW(11), .DIVISOR(e2c_pkg::DAYS_4Y), .SHIFT(24)
    ) u_quad_div (
        .aclk      (aclk),
        .en        (en),
        .dividend  (rd1_s4_reg),
        .quotient  (c4_s6),
        .remainder (rd2_s6)
    );

    e2c_cdiv #(
        .DW(17), .QW(5), .RW(12), .DIVISOR(3600), .SHIFT(24)
    ) u_hour_div (
        .aclk      (aclk),
        .en        (en),
        .dividend  (rems_s4_reg),
        .quotient  (hour_s6),
        .remainder (rh_s6)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            c100_s5_reg <= c100_s4_reg;
            c100_s6_reg <= c100_s5_reg;
            pre_s5_reg  <= pre_s4_reg;
            pre_s6_reg  <= pre_s5_reg;
        end
    end

    // Stage 7: single years within the 4-year cycle; the last day stays in year three.
    always_comb begin
        c1_next = 2'd0;
        if (rd2_s6 >= 11'(e2c_pkg::DAYS_1Y)) begin
            c1_next = 2'd1;
        end
        if (rd2_s6 >= 11'(2 * e2c_pkg::DAYS_1Y)) begin
            c1_next = 2'd2;
        end
        if (rd2_s6 >= 11'(3 * e2c_pkg::DAYS_1Y)) begin
            c1_next = 2'd3;
        end
    end

    assign rd3_next = 9'(rd2_s6 - 11'(c1_next) * 11'(e2c_pkg::DAYS_1Y));

    always_ff @(posedge aclk) begin
        if (en) begin
            c1_s7_reg   <= c1_next;
            rd3_s7_reg  <= rd3_next;
            c4_s7_reg   <= c4_s6;
            c100_s7_reg <= c100_s6_reg;
            hour_s7_reg <= hour_s6;
            pre_s7_reg  <= pre_s6_reg;
        end
    end

    // Stages 7 and 8: minutes and seconds of the hour remainder.
    e2c_cdiv #(
        .DW(12), .QW(6), .RW(6), .DIVISOR(60), .SHIFT(16)
    ) u_min_div (
        .aclk      (aclk),
        .en        (en),
        .dividend  (rh_s6),
        .quotient  (minute_s8),
        .remainder (second_s8)
    );

    // Stage 8: month lookup and the March-first year number.
    assign mon_next   = e2c_pkg::month_index(rd3_s7_reg);
    assign day_next   = 5'(rd3_s7_reg - e2c_pkg::MONTH_START[mon_next] + 9'd1);
    assign years_next = 12'd2000 + 12'(c1_s7_reg) + {5'd0, c4_s7_reg, 2'd0}
                        + (c100_s7_reg ? 12'd100 : 12'd0);

    always_ff @(posedge aclk) begin
        if (en) begin
            mon_s8_reg   <= mon_next;
            day_s8_reg   <= day_next;
            years_s8_reg <= years_next;
            hour_s8_reg  <= hour_s7_reg;
            pre_s8_reg   <= pre_s7_reg;
        end
    end

    // Stage 9: move to a January-first year, check the window and zero out-of-range items.
    assign mon_shift     = mon_s8_reg + 4'd2;
    assign mon_wrap      = (mon_shift >= 4'd12);
    assign month_calc    = mon_wrap ? mon_shift - 4'd11 : mon_shift + 4'd1;
    assign years_calc    = years_s8_reg + 12'(mon_wrap);
    assign in_range_calc = !pre_s8_reg && (years_calc >= YEAR_LO) && (years_calc <= YEAR_HI);

    always_comb begin
        tuser_next = 1'b0;
        tdata_next = '0;
        if (in_range_calc) begin
            tuser_next = 1'b1;
            tdata_next = {second_s8, minute_s8, hour_s8_reg, day_s8_reg, month_calc,
                          6'(years_calc - YEAR_LO)};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            tuser_reg <= tuser_next;
            tdata_reg <= tdata_next;
        end
    end

    // Checks on the pipeline control and the result encoding.
    `E2C_ASSERT_SAME(a_ready_only_on_stall, !s_tready, m_tvalid && !m_tready, "input blocked without an output stall")
    `E2C_ASSERT_NEXT(a_accept_enters, s_tvalid && s_tready, valid_reg[0], "accepted item missing in first stage")
    `E2C_ASSERT_SAME(a_zero_when_out, m_tvalid && !m_tuser, m_tdata == 32'd0, "out-of-range item carries nonzero fields")
    `E2C_ASSERT_SAME(a_month_legal, m_tvalid && m_tuser, (m_tdata[9:6] >= 4'd1) && (m_tdata[9:6] <= 4'd12) && (m_tdata[14:10] >= 5'd1), "month or day out of range")
    `E2C_ASSERT_SAME(a_time_legal, m_tvalid && m_tuser, (m_tdata[19:15] < 5'd24) && (m_tdata[25:20] < 6'd60) && (m_tdata[31:26] < 6'd60), "time of day out of range")

endmodule
